FILE: rtl/cbor_stream_token_decoder_top_assert.svh
// Assertion macros used by the CBOR token decoder top level.
`ifndef CBOR_STREAM_TOKEN_DECODER_TOP_ASSERT_SVH
`define CBOR_STREAM_TOKEN_DECODER_TOP_ASSERT_SVH
// Same-cycle implication, checked on clk, off during rst.
`define CSTD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, checked on clk, off during rst.
`define CSTD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

FILE: rtl/cstd_pkg.sv
// Package: shared types and codes for the CBOR token decoder.
`timescale 1ns / 1ps
`default_nettype none
package cstd_pkg;

  localparam int MAX_DEPTH_DEF = 16;

  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_HEAD    = 2'd1;
  localparam logic [1:0] EV_PAYLOAD = 2'd2;
  localparam logic [1:0] EV_ERROR   = 2'd3;

  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_RESERVED   = 3'd1;
  localparam logic [2:0] ERR_LONG_LEN   = 3'd2;
  localparam logic [2:0] ERR_EXTRA_ROOT = 3'd3;
  localparam logic [2:0] ERR_BAD_KEY    = 3'd4;
  localparam logic [2:0] ERR_OVERFLOW   = 3'd5;
  localparam logic [2:0] ERR_EMPTY      = 3'd6;
  localparam logic [2:0] ERR_UNFINISHED = 3'd7;

  localparam logic [2:0] MT_BYTES = 3'd2;
  localparam logic [2:0] MT_TEXT  = 3'd3;
  localparam logic [2:0] MT_ARRAY = 3'd4;
  localparam logic [2:0] MT_MAP   = 3'd5;
  localparam logic [2:0] MT_TAG   = 3'd6;

  localparam logic [4:0] INFO_ARG1     = 5'd24;
  localparam logic [4:0] INFO_ARG8     = 5'd27;
  localparam logic [4:0] INFO_RESERVED = 5'd28;

  typedef enum logic [1:0] {
    PH_HEAD,
    PH_ARG,
    PH_PAYLOAD,
    PH_AFTER_TAG
  } phase_t;

  typedef struct packed {
    logic        is_map;
    logic        next_key;
    logic [31:0] remaining;
  } stk_entry_t;

  typedef struct packed {
    logic       pop;
    logic       upd;
    logic       push;
    logic       clr;
    stk_entry_t upd_entry;
    stk_entry_t push_entry;
  } stk_cmd_t;

endpackage
`default_nettype wire

FILE: rtl/cstd_stack.sv
// Container stack: top entry in a register, lower entries in a synchronous RAM.
`timescale 1ns / 1ps
`default_nettype none
module cstd_stack #(
  parameter int MAX_DEPTH = cstd_pkg::MAX_DEPTH_DEF
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire  cstd_pkg::stk_cmd_t       cmd,
  output logic [$clog2(MAX_DEPTH+1)-1:0] lvl,
  output cstd_pkg::stk_entry_t           tos
);
  localparam int LW = $clog2(MAX_DEPTH + 1);
  localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  cstd_pkg::stk_entry_t mem [MAX_DEPTH];
  cstd_pkg::stk_entry_t below;
  cstd_pkg::stk_entry_t tos_a;
  logic [LW-1:0]        lvl_a;
  logic [LW-1:0]        lvl_next;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [AW-1:0]        rd_addr;

  always_comb begin
    lvl_a   = cmd.pop ? lvl - 1'b1 : lvl;
    tos_a   = cmd.pop ? below : (cmd.upd ? cmd.upd_entry : tos);
    wr_en   = cmd.push && (lvl_a != '0);
    wr_addr = AW'(lvl_a - 1'b1);
    if (cmd.clr) begin
      lvl_next = '0;
    end else if (cmd.push) begin
      lvl_next = lvl_a + 1'b1;
    end else begin
      lvl_next = lvl_a;
    end
    // entry just below the next top, ready for a pop next word
    if ({1'b0, lvl_next} >= (LW+1)'(2)) begin
      rd_addr = AW'(lvl_next - 1'b1 - 1'b1);
    end else begin
      rd_addr = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lvl <= '0;
    end else begin
      lvl <= lvl_next;
    end
  end

  always_ff @(posedge clk) begin
    tos <= cmd.push ? cmd.push_entry : tos_a;
    if (wr_en) begin
      mem[wr_addr] <= tos_a;
    end
    below <= (wr_en && (wr_addr == rd_addr)) ? tos_a : mem[rd_addr];
  end

endmodule
`default_nettype wire

FILE: rtl/cbor_stream_token_decoder_top.sv
// Top level: CBOR byte-stream token decoder with output register.
//
// Input channel: one message byte per word (data_byte, last_byte), with
// in_valid / in_stall. Output channel: one token word per input word
// (event_res .. error_code), with out_valid / out_stall.
// The result of a byte is registered and appears in the cycle after it
// is taken. Throughput: one byte per cycle unless the receiver stalls.
// Each byte touches at most one stack entry; the top of stack sits in a
// register, the entry below is prefetched from RAM: a pop is ready at once.
// A push in the same cycle as a read of that entry is forwarded.
// Errors are sticky: every byte reports an error word until last_byte.
// last_byte runs the completion checks and then clears all state, so the
// next byte starts a new message.
// Reset (rst, synchronous): parser idle, stack empty, output empty.
// No clearing pass: stack entries are only read once pushed.
// When the receiver stalls, the result word holds and in_stall rises;
// the word is released the cycle out_stall drops and a new byte is
// taken in that same cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "cbor_stream_token_decoder_top_assert.svh"
module cbor_stream_token_decoder_top #(
  parameter int MAX_DEPTH = cstd_pkg::MAX_DEPTH_DEF
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [7:0]  data_byte,
  input  wire         last_byte,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [1:0]  event_res,
  output logic [2:0]  major_type,
  output logic [63:0] argument,
  output logic [7:0]  payload_byte,
  output logic        payload_last,
  output logic        in_key_position,
  output logic [4:0]  depth,
  output logic        message_done,
  output logic [2:0]  error_code
);
  localparam int LW = $clog2(MAX_DEPTH + 1);

  // parser state
  cstd_pkg::phase_t phase, phase_next;
  logic [3:0]  pend, pend_next;
  logic [63:0] acc, acc_next;
  logic [2:0]  cur_major, cur_major_next;
  logic [31:0] pay_rem, pay_rem_next;
  logic        root, root_next;
  logic [2:0]  err_l, err_next;

  // stack
  cstd_pkg::stk_cmd_t   cmd;
  cstd_pkg::stk_entry_t tos;
  logic [LW-1:0]        lvl;

  // per-byte results
  logic        in_acc;
  logic [1:0]  ev;
  logic [2:0]  mt;
  logic [63:0] arg_o;
  logic [7:0]  pb;
  logic        pl, key_o, done;
  logic        fin;
  logic [2:0]  fin_major;
  logic [63:0] fin_arg;
  logic [2:0]  err;
  logic [2:0]  hd_major;
  logic [4:0]  hd_info;
  logic        is_tag, is_cont, map, nkey, key_n;
  logic [31:0] rem_n;
  logic [LW-1:0] lvl_a;

  assign in_stall = out_valid && out_stall;
  assign in_acc   = in_valid && !in_stall;

  cstd_stack #(.MAX_DEPTH(MAX_DEPTH)) u_stack (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .lvl      (lvl),
    .tos      (tos)
  );

  // byte decode and head placement
  always_comb begin
    phase_next     = phase;
    pend_next      = pend;
    acc_next       = acc;
    cur_major_next = cur_major;
    pay_rem_next   = pay_rem;
    root_next      = root;
    ev    = cstd_pkg::EV_NONE;
    mt    = '0;
    arg_o = '0;
    pb    = '0;
    pl    = 1'b0;
    key_o = 1'b0;
    done  = 1'b0;
    err   = cstd_pkg::ERR_NONE;
    fin       = 1'b0;
    fin_major = cur_major;
    fin_arg   = acc;
    hd_major  = data_byte[7:5];
    hd_info   = data_byte[4:0];
    cmd       = '0;
    map       = tos.is_map;
    nkey      = tos.next_key;
    key_n     = nkey;
    rem_n     = tos.remaining;
    lvl_a     = lvl;

    if (err_l == cstd_pkg::ERR_NONE) begin
      case (phase)
        cstd_pkg::PH_PAYLOAD: begin
          ev           = cstd_pkg::EV_PAYLOAD;
          mt           = cur_major;
          pb           = data_byte;
          pl           = (pay_rem == 32'd1);
          pay_rem_next = pay_rem - 32'd1;
          if (pay_rem == 32'd1) begin
            phase_next = cstd_pkg::PH_HEAD;
          end
        end
        cstd_pkg::PH_ARG: begin
          acc_next  = {acc[55:0], data_byte};
          mt        = cur_major;
          pend_next = (pend != 4'd0) ? pend - 4'd1 : 4'd0;
          if (pend_next == 4'd0) begin
            fin       = 1'b1;
            fin_major = cur_major;
            fin_arg   = acc_next;
          end
        end
        default: begin
          cur_major_next = hd_major;
          if (hd_info >= cstd_pkg::INFO_RESERVED) begin
            err = cstd_pkg::ERR_RESERVED;
          end else if (hd_info == cstd_pkg::INFO_ARG8 &&
                       hd_major inside {[cstd_pkg::MT_BYTES : cstd_pkg::MT_MAP]}) begin
            err = cstd_pkg::ERR_LONG_LEN;
          end else if (hd_info < cstd_pkg::INFO_ARG1) begin
            fin       = 1'b1;
            fin_major = hd_major;
            fin_arg   = {59'd0, hd_info};
          end else begin
            pend_next  = 4'(4'd1 << (hd_info - cstd_pkg::INFO_ARG1));
            acc_next   = '0;
            phase_next = cstd_pkg::PH_ARG;
            mt         = hd_major;
          end
        end
      endcase
    end

    is_tag  = (fin_major == cstd_pkg::MT_TAG);
    is_cont = (fin_major == cstd_pkg::MT_ARRAY) || (fin_major == cstd_pkg::MT_MAP);

    if (fin) begin
      ev    = cstd_pkg::EV_HEAD;
      mt    = fin_major;
      arg_o = fin_arg;
      if (lvl == '0) begin
        if (root) begin
          err = cstd_pkg::ERR_EXTRA_ROOT;
        end else if (!is_tag) begin
          root_next = 1'b1;
        end
      end else begin
        if (map && nkey) begin
          key_o = 1'b1;
          if (fin_major != cstd_pkg::MT_TEXT) begin
            err = cstd_pkg::ERR_BAD_KEY;
          end
        end
        if (!is_tag) begin
          if (map && nkey) begin
            key_n = 1'b0;
          end else begin
            if (map) begin
              key_n = 1'b1;
            end
            rem_n = tos.remaining - 32'd1;
          end
          if (rem_n == 32'd0) begin
            cmd.pop = 1'b1;
            lvl_a   = lvl - 1'b1;
          end else begin
            cmd.upd = 1'b1;
          end
          cmd.upd_entry = '{is_map: map, next_key: key_n, remaining: rem_n};
        end
      end
      if (err == cstd_pkg::ERR_NONE && is_cont && fin_arg != 64'd0) begin
        if ({1'b0, lvl_a} >= (LW+1)'(MAX_DEPTH)) begin
          err = cstd_pkg::ERR_OVERFLOW;
        end else begin
          cmd.push       = 1'b1;
          cmd.push_entry = '{is_map:    (fin_major == cstd_pkg::MT_MAP),
                             next_key:  (fin_major == cstd_pkg::MT_MAP),
                             remaining: fin_arg[31:0]};
        end
      end
      if (is_tag) begin
        phase_next = cstd_pkg::PH_AFTER_TAG;
      end else if ((fin_major == cstd_pkg::MT_BYTES || fin_major == cstd_pkg::MT_TEXT) &&
                   fin_arg != 64'd0) begin
        pay_rem_next = fin_arg[31:0];
        phase_next   = cstd_pkg::PH_PAYLOAD;
      end else begin
        phase_next = cstd_pkg::PH_HEAD;
      end
    end

    // errors leave the stack untouched; state is cleared at last byte anyway
    if (err != cstd_pkg::ERR_NONE || !in_acc) begin
      cmd.pop  = 1'b0;
      cmd.upd  = 1'b0;
      cmd.push = 1'b0;
    end
    cmd.clr = in_acc && last_byte;

    err_next = (err_l != cstd_pkg::ERR_NONE) ? err_l : err;
  end

  // completion checks and result word
  logic [2:0] err_fin;
  logic [LW-1:0] lvl_after;
  always_comb begin
    err_fin   = err_next;
    // depth before the clear that a last byte causes
    lvl_after = (err_next != cstd_pkg::ERR_NONE) ? lvl :
                (cmd.pop ? lvl - 1'b1 : lvl) + (cmd.push ? 1'b1 : 1'b0);
    if (err_next == cstd_pkg::ERR_NONE && last_byte) begin
      if (phase_next != cstd_pkg::PH_HEAD || lvl_after != '0) begin
        err_fin = cstd_pkg::ERR_UNFINISHED;
      end else if (!root_next) begin
        err_fin = cstd_pkg::ERR_EMPTY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= cstd_pkg::PH_HEAD;
      pend      <= '0;
      acc       <= '0;
      cur_major <= '0;
      pay_rem   <= '0;
      root      <= 1'b0;
      err_l     <= cstd_pkg::ERR_NONE;
    end else if (in_acc) begin
      if (last_byte) begin
        phase     <= cstd_pkg::PH_HEAD;
        pend      <= '0;
        acc       <= '0;
        cur_major <= '0;
        pay_rem   <= '0;
        root      <= 1'b0;
        err_l     <= cstd_pkg::ERR_NONE;
      end else begin
        phase     <= phase_next;
        pend      <= pend_next;
        acc       <= acc_next;
        cur_major <= cur_major_next;
        pay_rem   <= pay_rem_next;
        root      <= root_next;
        err_l     <= err_next;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_acc) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      depth      <= 5'(lvl_after);
      error_code <= err_fin;
      if (err_fin != cstd_pkg::ERR_NONE) begin
        event_res       <= cstd_pkg::EV_ERROR;
        major_type      <= '0;
        argument        <= '0;
        payload_byte    <= '0;
        payload_last    <= 1'b0;
        in_key_position <= 1'b0;
        message_done    <= 1'b0;
      end else begin
        event_res       <= ev;
        major_type      <= mt;
        argument        <= arg_o;
        payload_byte    <= pb;
        payload_last    <= pl;
        in_key_position <= key_o;
        message_done    <= last_byte;
      end
    end
  end

  `CSTD_ASSERT_NOW(a_err_word_has_code, out_valid && event_res == cstd_pkg::EV_ERROR, error_code != cstd_pkg::ERR_NONE, "error word without code")
  `CSTD_ASSERT_NOW(a_done_clean, out_valid && message_done, error_code == cstd_pkg::ERR_NONE && event_res != cstd_pkg::EV_ERROR, "done with error")
  `CSTD_ASSERT_NEXT(a_err_sticky, in_acc && !last_byte && err_l != cstd_pkg::ERR_NONE, err_l == $past(err_l), "latched error changed")
  `CSTD_ASSERT_NOW(a_lvl_bound, 1'b1, {1'b0, lvl} <= (LW+1)'(MAX_DEPTH), "stack level beyond depth")

endmodule
`default_nettype wire
